// ===== hw/rtl/sct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

    // Field widths at the ports.
    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned MAG_W   = 32;

    // Internal fixed point: magnitudes with 40 fraction bits.
    localparam int unsigned FRAC_W    = 40;
    localparam int unsigned TERM_W    = 48;
    localparam int unsigned X2_W      = 45;
    localparam int unsigned SUM_W     = 48;
    localparam int unsigned RECIP_W   = 40;
    localparam int unsigned SQ_W      = 64;
    localparam int unsigned SQ_SHIFT  = 18;
    localparam int unsigned OUT_SHIFT = 11;
    localparam int unsigned RMAG_W    = SUM_W - OUT_SHIFT;

    // Multiplier split into two halves per operand.
    localparam int unsigned MUL_W  = TERM_W;
    localparam int unsigned HALF_W = MUL_W / 2;
    localparam int unsigned FULL_W = 2 * MUL_W;

    // Saturation limits on the rounded magnitude.
    localparam logic [RMAG_W-1:0] POS_LIMIT = RMAG_W'(37'h0_7FFF_FFFF);
    localparam logic [RMAG_W-1:0] NEG_LIMIT = RMAG_W'(37'h0_8000_0000);
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    // Bound on any term and on x squared: 16.0 in Q.40.
    localparam logic [TERM_W-1:0] TERM_BOUND = TERM_W'(48'h1000_0000_0000);
    localparam logic [X2_W-1:0]   X2_BOUND   = X2_W'(45'h1000_0000_0000);

    // Data that travels with one item through the term stages.
    typedef struct packed {
        logic                    cosine;
        logic                    neg;
        logic [X2_W-1:0]         x2;
        logic signed [SUM_W-1:0] sum;
        logic [TERM_W-1:0]       term;
    } sct_lane_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sin_cos_taylor_series_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sine and cosine by a truncated Taylor series, one item per cycle while m_ready is high.
// Input channel: s_valid/s_ready with s_action (0 sine, 1 cosine) and
// s_angle, a signed Q2.29 angle in radians. There is no range reduction.
// Result channel: m_valid/m_ready with m_value, signed Q2.29, saturated.
// Every item gives exactly one result, in order.
// The pipeline has three front stages, four stages for each series term
// after the first (two split multipliers each) and three final stages
// that add the last term, round and saturate.
// Throughput: one item per cycle while m_ready is high.
// When a result waits at the output and m_ready is low, the whole pipeline
// holds and s_ready drops; nothing is lost or repeated. Empty slots still
// let new items in while the output register is empty.
// Reset (aresetn low, synchronous) clears all valid bits; the block is
// ready in the first cycle after reset.

module sin_cos_taylor_series_core #(
    parameter int unsigned NUM_TERMS = 12
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_action,
    input  wire logic signed [sct_pkg::ANGLE_W-1:0]  s_angle,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed      [sct_pkg::VALUE_W-1:0]  m_value
);
    import sct_pkg::*;

    // The last term, of index NUM_TERMS-1, is subtracted when that index is odd.
    localparam bit SUBTRACT_LAST = ((NUM_TERMS - 1) % 2) == 1;

    logic                    en;
    logic                    v0_reg;
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    cos0_reg;
    logic                    neg0_reg;
    logic [MAG_W-1:0]        mag0_reg;
    logic                    cos1_reg;
    logic                    neg1_reg;
    logic [MAG_W-1:0]        mag1_reg;
    logic [SQ_W-1:0]         sq1_reg;
    logic [SQ_W-1:0]         sq_round;
    sct_lane_t               lane0_reg;
    sct_lane_t               lane0_next;
    sct_lane_t               lane      [NUM_TERMS];
    logic                    lane_valid[NUM_TERMS];
    logic                    vf1_reg;
    logic                    vf2_reg;
    logic                    vf3_reg;
    logic signed [SUM_W-1:0] sum_f1_reg;
    logic signed [SUM_W-1:0] sum_f1_next;
    logic signed [SUM_W-1:0] last_term_s;
    logic                    flip_f1_reg;
    logic [SUM_W-1:0]        smag;
    logic [SUM_W-1:0]        smag_round;
    logic [RMAG_W-1:0]       rmag_f2_reg;
    logic                    sign_f2_reg;
    logic [VALUE_W-1:0]      value_next;
    logic [VALUE_W-1:0]      value_f3_reg;

    // The pipeline advances unless a result waits at the output.
    assign en      = m_ready || !vf3_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            vf1_reg <= 1'b0;
            vf2_reg <= 1'b0;
            vf3_reg <= 1'b0;
        end else if (en) begin
            v0_reg  <= s_valid;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            vf1_reg <= lane_valid[NUM_TERMS-1];
            vf2_reg <= vf1_reg;
            vf3_reg <= vf2_reg;
        end
    end

    // Front stages: magnitude, square, then x^2 in Q.40 and the first term.
    always_comb begin
        sq_round          = sq1_reg + (SQ_W'(1) << (SQ_SHIFT - 1));
        lane0_next.cosine = cos1_reg;
        lane0_next.neg    = neg1_reg;
        lane0_next.x2     = sq_round[X2_W+SQ_SHIFT-1:SQ_SHIFT];
        lane0_next.sum    = '0;
        if (cos1_reg) begin
            lane0_next.term = TERM_W'(1) << FRAC_W;
        end else begin
            lane0_next.term = TERM_W'({mag1_reg, {OUT_SHIFT{1'b0}}});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos0_reg  <= s_action;
            neg0_reg  <= s_angle[ANGLE_W-1];
            mag0_reg  <= s_angle[ANGLE_W-1] ? MAG_W'(-s_angle) : MAG_W'(s_angle);
            cos1_reg  <= cos0_reg;
            neg1_reg  <= neg0_reg;
            mag1_reg  <= mag0_reg;
            sq1_reg   <= SQ_W'(mag0_reg * mag0_reg);
            lane0_reg <= lane0_next;
        end
    end

    assign lane[0]       = lane0_reg;
    assign lane_valid[0] = v2_reg;

    // One four-stage section per further series term.
    for (genvar k = 1; k < NUM_TERMS; k++) begin : g_term
        sct_term #(
            .K (k)
        ) u_term (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (lane_valid[k-1]),
            .in_lane   (lane[k-1]),
            .out_valid (lane_valid[k]),
            .out_lane  (lane[k])
        );
    end

    // Fold the last term into the sum: subtracted when its index is odd, else added.
    always_comb begin
        last_term_s = signed'(SUM_W'(lane[NUM_TERMS-1].term));
        if (SUBTRACT_LAST) begin
            sum_f1_next = lane[NUM_TERMS-1].sum - last_term_s;
        end else begin
            sum_f1_next = lane[NUM_TERMS-1].sum + last_term_s;
        end
    end

    // Round the magnitude to Q2.29, half away from zero.
    always_comb begin
        smag       = sum_f1_reg[SUM_W-1] ? SUM_W'(-sum_f1_reg) : SUM_W'(sum_f1_reg);
        smag_round = smag + (SUM_W'(1) << (OUT_SHIFT - 1));
    end

    // Restore the sign and saturate.
    always_comb begin
        if (sign_f2_reg) begin
            if (rmag_f2_reg > NEG_LIMIT) begin
                value_next = VALUE_MIN;
            end else begin
                value_next = VALUE_W'(-rmag_f2_reg[VALUE_W-1:0]);
            end
        end else begin
            if (rmag_f2_reg > POS_LIMIT) begin
                value_next = VALUE_MAX;
            end else begin
                value_next = rmag_f2_reg[VALUE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_f1_reg   <= sum_f1_next;
            // Sine is odd: a negative angle flips the sign of the result.
            flip_f1_reg  <= !lane[NUM_TERMS-1].cosine && lane[NUM_TERMS-1].neg;
            rmag_f2_reg  <= smag_round[SUM_W-1:OUT_SHIFT];
            sign_f2_reg  <= sum_f1_reg[SUM_W-1] ^ flip_f1_reg;
            value_f3_reg <= value_next;
        end
    end

    assign m_valid = vf3_reg;
    assign m_value = signed'(value_f3_reg);

    // An accepted item always enters the first stage.
    a_accept_enters : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v0_reg)
        else $error("accepted item did not enter the pipeline");

    // x squared never exceeds 16.0, so the multipliers cannot overflow.
    a_x2_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (lane0_reg.x2 <= X2_BOUND))
        else $error("x squared out of range");

    // The last term stays below 16.0 in Q.40.
    a_term_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        lane_valid[NUM_TERMS-1] |-> (lane[NUM_TERMS-1].term < TERM_BOUND))
        else $error("series term out of range");

    // The sum keeps one spare sign bit, far from wrapping.
    a_sum_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        vf1_reg |-> (sum_f1_reg[SUM_W-1] == sum_f1_reg[SUM_W-2]))
        else $error("series sum out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/sct_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sct_mul (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic [sct_pkg::MUL_W-1:0] a,
    input  wire logic [sct_pkg::MUL_W-1:0] b,
    output logic      [sct_pkg::MUL_W-1:0] p
);
    import sct_pkg::*;

    logic [MUL_W-1:0]  ll_reg;
    logic [MUL_W-1:0]  lh_reg;
    logic [MUL_W-1:0]  hl_reg;
    logic [MUL_W-1:0]  hh_reg;
    logic [MUL_W-1:0]  p_reg;
    logic [FULL_W-1:0] full_next;

    // First stage: four half-width partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= MUL_W'(a[HALF_W-1:0] * b[HALF_W-1:0]);
            lh_reg <= MUL_W'(a[HALF_W-1:0] * b[MUL_W-1:HALF_W]);
            hl_reg <= MUL_W'(a[MUL_W-1:HALF_W] * b[HALF_W-1:0]);
            hh_reg <= MUL_W'(a[MUL_W-1:HALF_W] * b[MUL_W-1:HALF_W]);
        end
    end

    // Second stage: add the partial products and drop the 40 fraction bits.
    always_comb begin
        full_next = FULL_W'(ll_reg)
                  + (FULL_W'(lh_reg) << HALF_W)
                  + (FULL_W'(hl_reg) << HALF_W)
                  + (FULL_W'(hh_reg) << MUL_W);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= full_next[FRAC_W+MUL_W-1:FRAC_W];
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sct_term.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sct_term #(
    parameter int unsigned K = 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sct_pkg::sct_lane_t in_lane,
    output logic                    out_valid,
    output sct_pkg::sct_lane_t      out_lane
);
    import sct_pkg::*;

    // Reciprocals of n(n-1) in Q0.40 for the sine and cosine series.
    localparam longint unsigned N_SIN = 2 * K + 1;
    localparam longint unsigned N_COS = 2 * K;
    localparam longint unsigned M_SIN = N_SIN * (N_SIN - 1);
    localparam longint unsigned M_COS = N_COS * (N_COS - 1);
    localparam longint unsigned ONE_Q = 64'd1 << FRAC_W;
    localparam longint unsigned RECIP_SIN = (ONE_Q + M_SIN / 2) / M_SIN;
    localparam longint unsigned RECIP_COS = (ONE_Q + M_COS / 2) / M_COS;
    // The incoming term is the one of index K-1; odd indexes are subtracted.
    localparam bit SUBTRACT = ((K - 1) % 2) == 1;

    logic                    valid_a_reg;
    logic                    valid_b_reg;
    logic                    valid_c_reg;
    logic                    valid_d_reg;
    sct_lane_t               lane_a_reg;
    sct_lane_t               lane_b_reg;
    sct_lane_t               lane_c_reg;
    sct_lane_t               lane_d_reg;
    sct_lane_t               lane_a_next;
    logic signed [SUM_W-1:0] term_s;
    logic [MUL_W-1:0]        prod1;
    logic [MUL_W-1:0]        prod2;
    logic [MUL_W-1:0]        recip_sel;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
        end
    end

    // Fold the incoming term into the running sum while it is multiplied.
    always_comb begin
        term_s      = signed'(SUM_W'(in_lane.term));
        lane_a_next = in_lane;
        if (SUBTRACT) begin
            lane_a_next.sum = in_lane.sum - term_s;
        end else begin
            lane_a_next.sum = in_lane.sum + term_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_a_reg <= lane_a_next;
            lane_b_reg <= lane_a_reg;
            lane_c_reg <= lane_b_reg;
            lane_d_reg <= lane_c_reg;
        end
    end

    // term * x^2, two stages.
    sct_mul u_mul_x2 (
        .aclk (aclk),
        .en   (en),
        .a    (in_lane.term),
        .b    (MUL_W'(in_lane.x2)),
        .p    (prod1)
    );

    // Pick the reciprocal by the item's function select.
    assign recip_sel = lane_b_reg.cosine ? MUL_W'(RECIP_COS) : MUL_W'(RECIP_SIN);

    // (term * x^2) * 1/(n(n-1)), two stages.
    sct_mul u_mul_recip (
        .aclk (aclk),
        .en   (en),
        .a    (prod1),
        .b    (recip_sel),
        .p    (prod2)
    );

    always_comb begin
        out_lane      = lane_d_reg;
        out_lane.term = prod2;
    end

    assign out_valid = valid_d_reg;

endmodule

`default_nettype wire

// ===== sim/tb_sin_cos_taylor_series_core.sv =====
`timescale 1ns / 1ps

module tb_sin_cos_taylor_series_core;

    import sct_pkg::*;

    localparam int unsigned NUM_TERMS = 12;

    // Function select codes on s_action.
    localparam logic ACT_SINE   = 1'b0;
    localparam logic ACT_COSINE = 1'b1;

    // Per-cycle idle chance of either side, in percent.
    localparam int unsigned IDLE_PCT = 22;

    // Cycles that the receiver holds off while the sender keeps offering items.
    localparam int unsigned HOLD_OFF_LEN = 200;

    localparam int unsigned LATENCY = 4 * NUM_TERMS + 2;

    logic                        aclk;
    logic                        aresetn  = 1'b0;
    logic                        s_valid  = 1'b0;
    logic                        s_ready;
    logic                        s_action = ACT_SINE;
    logic signed [ANGLE_W-1:0]   s_angle  = '0;
    logic                        m_valid;
    logic                        m_ready  = 1'b0;
    logic signed [VALUE_W-1:0]   m_value;

    // Predicted values of the items that are in flight, oldest first.
    logic [VALUE_W-1:0] pending_values [$];
    logic [VALUE_W-1:0] oldest_value;
    int unsigned        mismatch_count = 0;

    // Idling controls shared by the test tasks and the receiver.
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    int unsigned hold_off_cycles = 0;

    sin_cos_taylor_series_core #(
        .NUM_TERMS(NUM_TERMS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_action(s_action),
        .s_angle (s_angle),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_value (m_value)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard limit on the run time.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Exact product of two Q.40 magnitudes, truncated back to Q.40.
    function automatic logic [63:0] mul_q40(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[103:40];
    endfunction

    // Expected series sum for one item, rounded and saturated to Q2.29.
    function automatic logic [VALUE_W-1:0] taylor_value(logic cos_sel,
                                                         logic [ANGLE_W-1:0] angle);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] recip;
        logic [63:0] smag;
        logic [63:0] rmag;
        longint      sum;
        longint      r;
        neg  = angle[ANGLE_W-1];
        mag  = neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
        x_sq = (mag * mag + (64'd1 << 17)) >> 18;
        term = cos_sel ? (64'd1 << 40) : (mag << 11);
        sum  = longint'(term);

        // Each term is the previous one times x squared over n(n-1).
        for (int k = 1; k < NUM_TERMS; k++) begin
            n     = cos_sel ? 64'(2 * k) : 64'(2 * k + 1);
            m     = n * (n - 64'd1);
            recip = ((64'd1 << 40) + (m >> 1)) / m;
            term  = mul_q40(mul_q40(term, x_sq), recip);
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end

        // Round the magnitude half away from zero, then restore the sign.
        if (sum < 0) begin
            smag = -sum;
            rmag = (smag + 64'd1024) >> 11;
            r    = -longint'(rmag);
        end else begin
            smag = sum;
            rmag = (smag + 64'd1024) >> 11;
            r    = longint'(rmag);
        end
        if (!cos_sel && neg) begin
            r = -r;
        end

        if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
        end
        if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
        end
        return 32'(r);
    endfunction

    // Angles are mostly uniform, with extra weight near zero and near +/-4.
    function automatic logic [ANGLE_W-1:0] random_angle();
        int unsigned pick;
        logic [ANGLE_W-1:0] small_mag;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return $urandom();
        end else if (pick < 8) begin
            small_mag = $urandom_range(0, 1 << 20);
            return $urandom_range(0, 1) ? -small_mag : small_mag;
        end else if (pick == 8) begin
            return 32'h8000_0000 + $urandom_range(0, 255);
        end else begin
            return 32'h7FFF_FFFF - $urandom_range(0, 255);
        end
    endfunction

    // Offer one item and return in the time step in which it is accepted.
    task automatic send_item(logic action, logic [ANGLE_W-1:0] angle);
        if (sender_idles && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                @(posedge aclk);
            end
        end
        s_valid  <= 1'b1;
        s_action <= action;
        s_angle  <= angle;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Receiver: random stalls, or a long counted hold-off when one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end else if (receiver_idles) begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Predict each accepted item and compare each result with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_values.push_back(taylor_value(s_action, s_angle));
            end
            if (m_valid && m_ready) begin
                if (pending_values.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result %h at %0t", m_value, $realtime);
                    end
                end else begin
                    oldest_value = pending_values.pop_front();
                    if (m_value !== oldest_value) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("value mismatch at %0t: expected %h, actual %h",
                                     $realtime, oldest_value, m_value);
                        end
                    end
                end
            end
        end
    end

    // Zero, smallest steps, both range ends, the most negative angle, and
    // familiar angles, each through sine and cosine.
    task automatic test_directed();
        logic [ANGLE_W-1:0] angles [12] = '{
            32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0001, 32'h3243_F6A9, 32'hCDBC_0957,
            32'h6487_ED51, 32'h9B78_12AF, 32'h2000_0000, 32'h7000_0000
        };
        foreach (angles[i]) begin
            send_item(ACT_SINE, angles[i]);
            send_item(ACT_COSINE, angles[i]);
        end
    endtask

    // Random items with random idling on both sides.
    task automatic test_random_traffic(int unsigned count);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        repeat (count) begin
            send_item(logic'($urandom_range(0, 1)), random_angle());
        end
    endtask

    // A long stretch at full rate with no idling anywhere.
    task automatic test_back_to_back(int unsigned count);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (count) begin
            send_item(logic'($urandom_range(0, 1)), random_angle());
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // The receiver holds off while items keep coming, so the pipeline fills
    // and the input stalls.
    task automatic test_output_hold_off(int unsigned count);
        sender_idles    = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        repeat (count) begin
            send_item(logic'($urandom_range(0, 1)), random_angle());
        end
        sender_idles = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(470);
        test_back_to_back(80);
        test_output_hold_off(80);
        test_random_traffic(30);
        s_valid <= 1'b0;

        // Let every result arrive, then watch for strays.
        while (pending_values.size() != 0) begin
            @(posedge aclk);
        end
        repeat (LATENCY + 16) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sct_pkg.sv
hw/rtl/sct_mul.sv
hw/rtl/sct_term.sv
hw/rtl/sin_cos_taylor_series_core.sv
sim/tb_sin_cos_taylor_series_core.sv
